>>> design/mat_pkg.sv
package mat_pkg;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_DEL    = 2'd2;

  // Status codes returned with each result item.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_MC    = 3'd4;

  // Top byte that marks an IPv6 multicast address.
  localparam logic [7:0] MC_PREFIX = 8'hff;

  // One stored entry is both address halves side by side.
  localparam int ENTRY_W = 128;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [3:0] slot;
    logic [4:0] entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_init;
    logic shift;
    logic append;
    logic report;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_done;
    logic stream_done;
    logic hit_now;
    logic mc;
    logic full;
    logic is_add;
    logic is_del;
  } dp_status_t;

endpackage

>>> design/mat_ram.sv
module mat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/mat_ctrl.sv
module mat_ctrl
  import mat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t sts,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_SHIFT,
    S_REPORT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and the command for the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.mc && sts.is_add && !sts.hit_now && !sts.full) begin
            state_nxt = S_APPEND;
          end else if (sts.mc && sts.is_del && sts.hit_now) begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end else begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_REPORT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.stream_done) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new item is taken only while idle.
  assign busy = (state_r != S_IDLE);

endmodule

>>> design/mat_dp.sv
module mat_dp
  import mat_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       out_valid,
  output out_item_t  out_item
);

  // Latched item.
  logic [1:0]  act_r, act_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic        mc_r, mc_nxt;
  logic        full_r, full_nxt;

  // Table occupancy and the read stream.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Memory ports.
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic match;
  logic issue;
  logic stream_end;

  mat_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The entry read last cycle against the latched address.
  assign match      = (rd_data == {hi_r, lo_r});
  assign issue      = ((cmd.scan && mc_r) || cmd.shift) && (rd_idx_r < cnt_r);
  assign stream_end = !pend_r && (rd_idx_r >= cnt_r);

  // Status for the controller.
  always_comb begin
    sts.hit_now     = pend_r && match;
    sts.scan_done   = !mc_r || (pend_r && match) || stream_end;
    sts.stream_done = stream_end;
    sts.mc          = mc_r;
    sts.full        = full_r;
    sts.is_add      = (act_r == ACT_ADD);
    sts.is_del      = (act_r == ACT_DEL);
  end

  // Datapath next-state logic.
  always_comb begin
    act_nxt       = act_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    mc_nxt        = mc_r;
    full_nxt      = full_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_en         = issue;
    rd_addr       = rd_idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = {hi_r, lo_r};

    // Take a new item and restart the walk at entry zero.
    if (cmd.load) begin
      act_nxt     = in_item.action;
      hi_nxt      = in_item.addr_high;
      lo_nxt      = in_item.addr_low;
      mc_nxt      = (in_item.addr_high[63:56] == MC_PREFIX);
      full_nxt    = (cnt_r == CW'(DEPTH));
      rd_idx_nxt  = '0;
      pend_nxt    = 1'b0;
      hit_nxt     = 1'b0;
      hit_idx_nxt = '0;
    end

    // Issue one read a cycle; its data is checked or moved the next cycle.
    if (cmd.scan || cmd.shift) begin
      pend_nxt     = issue;
      pend_idx_nxt = rd_idx_r[AW-1:0];
      if (issue) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
    end

    if (cmd.scan && pend_r && match) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = pend_idx_r;
    end

    // Compaction starts reading just past the matching entry.
    if (cmd.shift_init) begin
      rd_idx_nxt = CW'(pend_idx_r) + CW'(1);
      pend_nxt   = 1'b0;
    end

    // Each entry read during compaction lands one slot lower.
    if (cmd.shift && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx_r - AW'(1);
      wr_data = rd_data;
    end

    if (cmd.shift && stream_end) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    // Append at the end of the list.
    if (cmd.append) begin
      wr_en   = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
    end

    // Build the result item.
    if (cmd.report) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.entry_count = 5'(cnt_r);
      if (!mc_r) begin
        out_item_nxt.status = ST_NOT_MC;
        out_item_nxt.found  = 1'b0;
        out_item_nxt.slot   = '0;
      end else begin
        out_item_nxt.found = hit_r;
        out_item_nxt.slot  = hit_r ? 4'(hit_idx_r) : 4'd0;
        if (act_r == ACT_ADD) begin
          if (hit_r) begin
            out_item_nxt.status = ST_PRESENT;
          end else if (full_r) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            out_item_nxt.status = ST_OK;
          end
        end else begin
          out_item_nxt.status = hit_r ? ST_OK : ST_NOT_FOUND;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    mc_r       <= mc_nxt;
    full_r     <= full_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/multicast_address_table_top.sv
// Each item is latched, then the table is read entry by entry until a match or the end of the
// list. An add that misses appends unless the table is full, a delete that hits moves the later
// entries down one slot, and an address without the multicast prefix is reported without a walk.
// Throughput: one item at a time, one entry read a cycle; the next item is taken from the cycle
// its result shows. The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (synchronous, rst_n low) empties the table; no clearing pass is needed.
module multicast_address_table_top
  import mat_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  mat_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  mat_dp #(
    .DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Result strobes never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes back to back");

  // A rejected address reports no match.
  a_not_mc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_NOT_MC) |-> (!out_item.found && out_item.slot == 4'd0))
    else $error("non-multicast result carries a match");

  // An add of a present address always reports the match.
  a_present_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_PRESENT) |-> out_item.found)
    else $error("already-present status without found");
`endif

endmodule

>>> dv/tb_top.sv
module tb_top
  import mat_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX = 10;
  // Action code 3 has no name in the package; the block treats it as a lookup.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  // Items waiting to be sent and replies the table is expected to give.
  in_item_t  pending_items[$];
  out_item_t table_replies_due[$];

  // Shadow copy of the table contents.
  logic [63:0] shadow_hi[TABLE_DEPTH];
  logic [63:0] shadow_lo[TABLE_DEPTH];
  int          shadow_count = 0;

  // Address pool used to make random items hit the table often.
  logic [63:0] pool_hi[POOL_SIZE];
  logic [63:0] pool_lo[POOL_SIZE];

  int gap_pct = 0;
  int gap_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  multicast_address_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one action to the shadow table and return the reply it should produce.
  function automatic out_item_t apply_table_action(in_item_t it);
    out_item_t r;
    logic      hit;
    int        idx;
    int        j;
    r = '0;
    hit = 1'b0;
    idx = 0;
    if (it.addr_high[63:56] != MC_PREFIX) begin
      r.status = ST_NOT_MC;
    end else begin
      for (j = 0; j < shadow_count; j++) begin
        if (!hit && shadow_hi[j] == it.addr_high && shadow_lo[j] == it.addr_low) begin
          hit = 1'b1;
          idx = j;
        end
      end
      r.found = hit;
      r.slot = hit ? 4'(idx) : 4'd0;
      case (it.action)
        ACT_ADD: begin
          if (hit) begin
            r.status = ST_PRESENT;
          end else if (shadow_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            shadow_hi[shadow_count] = it.addr_high;
            shadow_lo[shadow_count] = it.addr_low;
            shadow_count++;
            r.status = ST_OK;
          end
        end
        ACT_DEL: begin
          if (hit) begin
            // Later entries move down one slot to keep the list compact.
            for (j = idx; j + 1 < shadow_count; j++) begin
              shadow_hi[j] = shadow_hi[j + 1];
              shadow_lo[j] = shadow_lo[j + 1];
            end
            shadow_count--;
            r.status = ST_OK;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: begin
          r.status = hit ? ST_OK : ST_NOT_FOUND;
        end
      endcase
    end
    r.entry_count = 5'(shadow_count);
    return r;
  endfunction

  // Sender: accepted items update the shadow table, then the next item or a gap follows.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        table_replies_due.push_back(apply_table_action(in_item));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 13);
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver: each strobed reply is checked against the oldest one due.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (table_replies_due.size() == 0) begin
        if (error_count < REPORT_MAX) begin
          $display("unexpected reply: status=%0d found=%0d slot=%0d count=%0d",
                   out_item.status, out_item.found, out_item.slot, out_item.entry_count);
        end
        error_count++;
      end else begin
        want = table_replies_due.pop_front();
        if (out_item.status !== want.status || out_item.found !== want.found ||
            out_item.slot !== want.slot || out_item.entry_count !== want.entry_count) begin
          if (error_count < REPORT_MAX) begin
            $display("mismatch: expected status=%0d found=%0d slot=%0d count=%0d",
                     want.status, want.found, want.slot, want.entry_count);
            $display("          actual   status=%0d found=%0d slot=%0d count=%0d",
                     out_item.status, out_item.found, out_item.slot, out_item.entry_count);
          end
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(logic [1:0] action, logic [63:0] hi, logic [63:0] lo);
    in_item_t it;
    it.action = action;
    it.addr_high = hi;
    it.addr_low = lo;
    pending_items.push_back(it);
  endtask

  // Checked on the falling edge, after the sender's updates of the rising edge have settled.
  task automatic wait_for_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || start || table_replies_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // New pool of multicast addresses, with neighbors that share one half or differ in one bit.
  task automatic refresh_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_hi[i] = {MC_PREFIX, 24'($urandom), $urandom};
      pool_lo[i] = {$urandom, $urandom};
      if (i > 0) begin
        case ($urandom_range(0, 3))
          1: pool_hi[i] = pool_hi[i - 1];
          2: pool_lo[i] = pool_lo[i - 1];
          3: begin
            pool_hi[i] = pool_hi[i - 1];
            pool_lo[i] = pool_lo[i - 1] ^ (64'd1 << $urandom_range(0, 63));
          end
          default: ;
        endcase
      end
    end
  endtask

  function automatic in_item_t random_item(int add_pct, int del_pct);
    in_item_t it;
    int       r;
    int       k;
    r = $urandom_range(0, 99);
    if (r < add_pct) it.action = ACT_ADD;
    else if (r < add_pct + del_pct) it.action = ACT_DEL;
    else if (r < 96) it.action = ACT_LOOKUP;
    else it.action = ACT_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      k = $urandom_range(0, POOL_SIZE - 1);
      it.addr_high = pool_hi[k];
      it.addr_low = pool_lo[k];
    end else if (r < 93) begin
      it.addr_high = {MC_PREFIX, 24'($urandom), $urandom};
      it.addr_low = {$urandom, $urandom};
    end else begin
      // Anything without the multicast prefix in the top byte.
      it.addr_high = {$urandom, $urandom};
      it.addr_low = {$urandom, $urandom};
      if (it.addr_high[63:56] == MC_PREFIX) begin
        k = $urandom_range(56, 63);
        it.addr_high[k] = ~it.addr_high[k];
      end
    end
    return it;
  endfunction

  initial begin
    logic [63:0] a_hi;
    logic [63:0] a_lo;
    int          i;
    int          p;
    a_hi = 64'hff02_0000_0000_0000;
    a_lo = 64'h0000_0000_0000_0001;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      shadow_hi[i] = '0;
      shadow_lo[i] = '0;
    end
    refresh_pool();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: empty table, rejected addresses, hits, misses, a full table.
    send(ACT_LOOKUP, a_hi, a_lo);
    send(ACT_ADD, 64'h0, 64'h0);
    send(ACT_DEL, 64'hfeff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send(ACT_UNUSED, 64'h7fff_ffff_ffff_ffff, a_lo);
    send(ACT_ADD, a_hi, a_lo);
    send(ACT_ADD, a_hi, a_lo);
    send(ACT_LOOKUP, a_hi, a_lo);
    send(ACT_UNUSED, a_hi, a_lo);
    send(ACT_DEL, 64'hff00_0000_0000_0000, 64'h0);
    send(ACT_ADD, a_hi, ~a_lo);
    send(ACT_DEL, a_hi, a_lo);
    send(ACT_DEL, a_hi, ~a_lo);
    send(ACT_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send(ACT_ADD, 64'hff00_0000_0000_0000, 64'h0);
    for (i = 0; i < TABLE_DEPTH - 2; i++) begin
      send(ACT_ADD, {MC_PREFIX, 8'h02, 48'(i)}, {$urandom, $urandom});
    end
    send(ACT_ADD, a_hi, a_lo);
    send(ACT_DEL, 64'hff00_0000_0000_0000, 64'h0);
    send(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);

    // The test waits until every reply of the directed part is in.
    wait_for_idle();

    // Random phases alternate between filling and draining the table.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 5) begin
        wait_for_idle();
      end
      if (p % 3 == 0) begin
        refresh_pool();
      end
      gap_pct = (p >= NUM_PHASES - 2 || p == 3) ? 0 : 15 + 10 * (p % 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p % 2 == 0) pending_items.push_back(random_item(60, 20));
        else pending_items.push_back(random_item(20, 60));
      end
      while (pending_items.size() != 0) begin
        @(posedge clk);
      end
    end

    wait_for_idle();
    repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
